[rtl/lisc_pkg.sv]
`default_nettype none
// ============================================================================
// lisc_pkg
// Shared codes and control types of the LRU image slot cache: result kinds,
// configuration register indexes and the command groups sent to the cells.
// ============================================================================
package lisc_pkg;

    localparam int KIND_W    = 3;
    localparam int ID_W      = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int OUT_SLOT_W = 4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEFAULT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HIT      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FILLED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FETCH    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NOSLOT   = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 2'd2;

    localparam logic [ID_W-1:0] RESERVE_LIMIT_RESET = 32'd100;
    localparam int              SLOT_COUNT_RESET    = 16;

    // Commands broadcast to every cell of the recency list.
    typedef struct packed {
        logic shift;    // cells at or above the given position take their neighbor
        logic append;   // the cell at the tail position takes the new entry
    } lru_cmd_t;

    // Commands broadcast to every cell of the free queue.
    typedef struct packed {
        logic init;     // reload the cell with its own slot number
        logic pop;      // every cell takes its neighbor
        logic push;     // the cell at the tail position takes the pushed slot
    } free_cmd_t;

endpackage
`default_nettype wire

[rtl/lisc_lru_cell.sv]
`default_nettype none
// ============================================================================
// lisc_lru_cell
// One position of the recency list: holds a slot number and its owner and
// mark tags, compares the tags with the request and shifts toward the head.
// ============================================================================
module lisc_lru_cell #(
    parameter int SW  = 4,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire                        aclk,
    input  lisc_pkg::lru_cmd_t         cmd,
    input  wire [CW-1:0]               pos,
    input  wire [CW-1:0]               tail,
    input  wire [lisc_pkg::ID_W-1:0]   req_owner,
    input  wire [lisc_pkg::ID_W-1:0]   req_mark,
    input  wire [SW-1:0]               new_slot,
    input  wire [SW-1:0]               nb_slot,
    input  wire [lisc_pkg::ID_W-1:0]   nb_owner,
    input  wire [lisc_pkg::ID_W-1:0]   nb_mark,
    output logic [SW-1:0]              slot_q,
    output logic [lisc_pkg::ID_W-1:0]  owner_q,
    output logic [lisc_pkg::ID_W-1:0]  mark_q,
    output logic                       owner_hit,
    output logic                       mark_hit
);
    import lisc_pkg::*;

    logic [SW-1:0]   slot_reg,  slot_next;
    logic [ID_W-1:0] owner_reg, owner_next;
    logic [ID_W-1:0] mark_reg,  mark_next;

    always_comb begin
        slot_next  = slot_reg;
        owner_next = owner_reg;
        mark_next  = mark_reg;
        if (cmd.append && (tail == CW'(IDX))) begin
            slot_next  = new_slot;
            owner_next = req_owner;
            mark_next  = req_mark;
        end else if (cmd.shift && (CW'(IDX) >= pos)) begin
            slot_next  = nb_slot;
            owner_next = nb_owner;
            mark_next  = nb_mark;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        owner_reg <= owner_next;
        mark_reg  <= mark_next;
    end

    assign slot_q    = slot_reg;
    assign owner_q   = owner_reg;
    assign mark_q    = mark_reg;
    assign owner_hit = (owner_reg == req_owner);
    assign mark_hit  = (mark_reg == req_mark);

endmodule
`default_nettype wire

[rtl/lisc_free_cell.sv]
`default_nettype none
// ============================================================================
// lisc_free_cell
// One position of the free slot queue: holds a slot number, moves toward
// the head on a pop and takes a returned slot when it is the tail.
// ============================================================================
module lisc_free_cell #(
    parameter int SW  = 4,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  lisc_pkg::free_cmd_t cmd,
    input  wire [CW-1:0]        tail,
    input  wire [SW-1:0]        push_slot,
    input  wire [SW-1:0]        nb_slot,
    output logic [SW-1:0]       slot_q
);
    import lisc_pkg::*;

    logic [SW-1:0] slot_reg, slot_next;

    always_comb begin
        slot_next = slot_reg;
        if (cmd.init) begin
            slot_next = SW'(IDX);
        end else if (cmd.pop) begin
            slot_next = nb_slot;
        end else if (cmd.push && (tail == CW'(IDX))) begin
            slot_next = push_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= SW'(IDX);
        end else begin
            slot_reg <= slot_next;
        end
    end

    assign slot_q = slot_reg;

endmodule
`default_nettype wire

[rtl/lru_image_slot_cache.sv]
`default_nettype none
// ============================================================================
// lru_image_slot_cache
// Fully associative image slot cache with least-recently-used replacement
// and a free slot queue, built as two rows of cells.
// ============================================================================
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------
//  s_      | in        | s_valid / s_ready     | s_owner_id, s_mark_id, s_data_ready
//  m_      | out       | m_valid / m_ready     | m_kind, m_slot, m_evicted
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Requests with owner zero, default marks or reserved marks go from the idle
// state straight to the done state, which loads the output register once it
// is free. A cache lookup walks the recency list one position a cycle from the
// least recent end; a miss with ready data, the longest case, passes through
// the search, miss, append and done states before its result is put out.
// Reset is synchronous: the list is emptied and the free queue holds slots
// 0 to min(16, SLOTS) - 1. A write of slot_count also empties the list and
// loads the free queue with slots 0 to min(cfg_data[4:0], SLOTS) - 1.
// A new item is accepted while the previous result still waits in the output
// register; a stalled output only holds the block in its final state.
// ============================================================================
module lru_image_slot_cache #(
    parameter int SLOTS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,

    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire [lisc_pkg::ID_W-1:0]             s_owner_id,
    input  wire [lisc_pkg::ID_W-1:0]             s_mark_id,
    input  wire                                  s_data_ready,

    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [lisc_pkg::KIND_W-1:0]          m_kind,
    output logic [lisc_pkg::OUT_SLOT_W-1:0]      m_slot,
    output logic                                 m_evicted,

    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [lisc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [lisc_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import lisc_pkg::*;

    // Slot numbers need SW bits; counts of slots run from 0 to SLOTS.
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RESET_SLOTS = (SLOTS < SLOT_COUNT_RESET) ? SLOTS : SLOT_COUNT_RESET;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_MISS   = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [CW-1:0]     free_len_reg, free_len_next;
    logic [ID_W-1:0]   owner_reg, owner_next;
    logic [ID_W-1:0]   mark_reg, mark_next;
    logic              ready_reg, ready_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic              ev_reg, ev_next;
    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] m_kind_reg, m_kind_next;
    logic [OUT_SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_evicted_reg, m_evicted_next;
    logic [7:0]        default_count_reg, default_count_next;
    logic [ID_W-1:0]   reserve_limit_reg, reserve_limit_next;

    // Cell row wiring.
    logic [SW-1:0]   lru_slot  [SLOTS];
    logic [ID_W-1:0] lru_owner [SLOTS];
    logic [ID_W-1:0] lru_mark  [SLOTS];
    logic [SW-1:0]   lru_nb_slot  [SLOTS];
    logic [ID_W-1:0] lru_nb_owner [SLOTS];
    logic [ID_W-1:0] lru_nb_mark  [SLOTS];
    logic [SLOTS-1:0] lru_owner_hit;
    logic [SLOTS-1:0] lru_mark_hit;
    logic [SW-1:0]   free_slot    [SLOTS];
    logic [SW-1:0]   free_nb_slot [SLOTS];

    lru_cmd_t      lru_cmd;
    logic [CW-1:0] lru_pos;
    free_cmd_t     free_cmd;

    logic          cur_hit;
    logic          cur_mhit;
    logic [SW-1:0] cur_slot;
    logic          out_free;
    logic          cfg_fire;
    logic [4:0]    cfg_count;

    // ------------------------------------------------------------------------
    // Recency list: cell 0 holds the least recently used slot.
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < SLOTS; i++) begin : g_lru
        if (i == SLOTS - 1) begin : g_last
            assign lru_nb_slot[i]  = '0;
            assign lru_nb_owner[i] = '0;
            assign lru_nb_mark[i]  = '0;
        end else begin : g_mid
            assign lru_nb_slot[i]  = lru_slot[i+1];
            assign lru_nb_owner[i] = lru_owner[i+1];
            assign lru_nb_mark[i]  = lru_mark[i+1];
        end

        lisc_lru_cell #(
            .SW  (SW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (lru_cmd),
            .pos       (lru_pos),
            .tail      (len_reg),
            .req_owner (owner_reg),
            .req_mark  (mark_reg),
            .new_slot  (slot_reg),
            .nb_slot   (lru_nb_slot[i]),
            .nb_owner  (lru_nb_owner[i]),
            .nb_mark   (lru_nb_mark[i]),
            .slot_q    (lru_slot[i]),
            .owner_q   (lru_owner[i]),
            .mark_q    (lru_mark[i]),
            .owner_hit (lru_owner_hit[i]),
            .mark_hit  (lru_mark_hit[i])
        );
    end

    // ------------------------------------------------------------------------
    // Free queue: cell 0 is the head.
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < SLOTS; i++) begin : g_free
        if (i == SLOTS - 1) begin : g_last
            assign free_nb_slot[i] = '0;
        end else begin : g_mid
            assign free_nb_slot[i] = free_slot[i+1];
        end

        lisc_free_cell #(
            .SW  (SW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (free_cmd),
            .tail      (free_len_reg),
            .push_slot (cur_slot),
            .nb_slot   (free_nb_slot[i]),
            .slot_q    (free_slot[i])
        );
    end

    // The walk looks at one list position per cycle; the selected cell's
    // compare results and slot number are picked out by the walk counter.
    always_comb begin
        cur_hit  = 1'b0;
        cur_mhit = 1'b0;
        cur_slot = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (k_reg == CW'(i)) begin
                cur_hit  = cur_hit | lru_owner_hit[i];
                cur_mhit = cur_mhit | lru_mark_hit[i];
                cur_slot = cur_slot | lru_slot[i];
            end
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_count = cfg_data[4:0];

    always_comb begin
        state_next         = state_reg;
        k_next             = k_reg;
        len_next           = len_reg;
        free_len_next      = free_len_reg;
        owner_next         = owner_reg;
        mark_next          = mark_reg;
        ready_next         = ready_reg;
        kind_next          = kind_reg;
        slot_next          = slot_reg;
        ev_next            = ev_reg;
        m_valid_next       = m_valid_reg;
        m_kind_next        = m_kind_reg;
        m_slot_next        = m_slot_reg;
        m_evicted_next     = m_evicted_reg;
        default_count_next = default_count_reg;
        reserve_limit_next = reserve_limit_reg;
        lru_cmd            = '0;
        lru_pos            = k_reg;
        free_cmd           = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    owner_next = s_owner_id;
                    mark_next  = s_mark_id;
                    ready_next = s_data_ready;
                    slot_next  = '0;
                    ev_next    = 1'b0;
                    k_next     = '0;
                    // Order of checks: no owner, built-in mark, reserved mark.
                    priority if (s_owner_id == '0) begin
                        kind_next  = KIND_NONE;
                        state_next = ST_DONE;
                    end else if (s_mark_id < {24'd0, default_count_reg}) begin
                        kind_next  = KIND_DEFAULT;
                        state_next = ST_DONE;
                    end else if (s_mark_id <= reserve_limit_reg) begin
                        kind_next  = KIND_RESERVED;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                if (k_reg == len_reg) begin
                    state_next = ST_MISS;
                end else if (cur_hit) begin
                    // The first entry of this owner leaves the list; the
                    // cells behind it close the gap.
                    lru_cmd.shift = 1'b1;
                    len_next      = len_reg - 1'b1;
                    slot_next     = cur_slot;
                    if (cur_mhit) begin
                        kind_next  = KIND_HIT;
                        state_next = ST_APPEND;
                    end else begin
                        // Stale mark: the slot goes back to the free queue.
                        free_cmd.push = 1'b1;
                        free_len_next = free_len_reg + 1'b1;
                        state_next    = ST_MISS;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end

            ST_MISS: begin
                priority if (!ready_reg) begin
                    kind_next  = KIND_FETCH;
                    slot_next  = '0;
                    state_next = ST_DONE;
                end else if (free_len_reg != '0) begin
                    slot_next     = free_slot[0];
                    free_cmd.pop  = 1'b1;
                    free_len_next = free_len_reg - 1'b1;
                    kind_next     = KIND_FILLED;
                    state_next    = ST_APPEND;
                end else if (len_reg != '0) begin
                    // Evict the least recent slot: the whole list moves up.
                    slot_next     = lru_slot[0];
                    lru_cmd.shift = 1'b1;
                    lru_pos       = '0;
                    len_next      = len_reg - 1'b1;
                    ev_next       = 1'b1;
                    kind_next     = KIND_FILLED;
                    state_next    = ST_APPEND;
                end else begin
                    kind_next  = KIND_NOSLOT;
                    slot_next  = '0;
                    state_next = ST_DONE;
                end
            end

            ST_APPEND: begin
                // The slot becomes most recent, tagged with the request.
                lru_cmd.append = 1'b1;
                len_next       = len_reg + 1'b1;
                state_next     = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = kind_reg;
                    m_slot_next    = OUT_SLOT_W'(slot_reg);
                    m_evicted_next = ev_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes are to arrive only while the block is idle; the block itself does not enforce this.
        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_DEFAULT_COUNT: begin
                    default_count_next = cfg_data[7:0];
                end
                CFG_RESERVE_LIMIT: begin
                    reserve_limit_next = cfg_data;
                end
                CFG_SLOT_COUNT: begin
                    free_cmd.init = 1'b1;
                    len_next      = '0;
                    if (32'(cfg_count) > SLOTS) begin
                        free_len_next = CW'(SLOTS);
                    end else begin
                        free_len_next = CW'(cfg_count);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            len_reg           <= '0;
            free_len_reg      <= CW'(RESET_SLOTS);
            m_valid_reg       <= 1'b0;
            default_count_reg <= '0;
            reserve_limit_reg <= RESERVE_LIMIT_RESET;
        end else begin
            state_reg         <= state_next;
            len_reg           <= len_next;
            free_len_reg      <= free_len_next;
            m_valid_reg       <= m_valid_next;
            default_count_reg <= default_count_next;
            reserve_limit_reg <= reserve_limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        owner_reg     <= owner_next;
        mark_reg      <= mark_next;
        ready_reg     <= ready_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        ev_reg        <= ev_next;
        m_kind_reg    <= m_kind_next;
        m_slot_reg    <= m_slot_next;
        m_evicted_reg <= m_evicted_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_slot    = m_slot_reg;
    assign m_evicted = m_evicted_reg;

endmodule
`default_nettype wire
